// ===== rtl/core/tcfs_pkg.sv =====
// Shared types and constants for the first-seen source traffic classifier.
// No dependencies; used by every module in rtl/core except tcfs_ram.

package tcfs_pkg;

	// Default depth of the seen-source table
	localparam int TABLE_DEPTH = 128;

	// Header codes
	localparam logic [15:0] ETHER_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// Category codes
	localparam logic [1:0] CAT_NONE  = 2'd0;
	localparam logic [1:0] CAT_FILE  = 2'd1;
	localparam logic [1:0] CAT_GAME  = 2'd2;
	localparam logic [1:0] CAT_VOICE = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_BULK_A      = 3'd0;
	localparam logic [2:0] REG_BULK_B      = 3'd1;
	localparam logic [2:0] REG_GAME_A      = 3'd2;
	localparam logic [2:0] REG_GAME_B      = 3'd3;
	localparam logic [2:0] REG_EXCL_PORT   = 3'd4;
	localparam logic [2:0] REG_VOICE_PORT  = 3'd5;
	localparam logic [2:0] REG_VOICE_LMIN  = 3'd6;
	localparam logic [2:0] REG_VOICE_LMAX  = 3'd7;

	// Register reset values
	localparam logic [15:0] RST_BULK_A     = 16'd1514;
	localparam logic [15:0] RST_BULK_B     = 16'd1434;
	localparam logic [15:0] RST_GAME_A     = 16'd66;
	localparam logic [15:0] RST_GAME_B     = 16'd76;
	localparam logic [15:0] RST_EXCL_PORT  = 16'd53;
	localparam logic [15:0] RST_VOICE_PORT = 16'd1024;
	localparam logic [15:0] RST_VOICE_LMIN = 16'd150;
	localparam logic [15:0] RST_VOICE_LMAX = 16'd300;

	// Classified command from front to back
	typedef struct packed {
		logic        is_tcp;
		logic        is_udp;
		logic        try_insert;
		logic [1:0]  cat;
		logic [31:0] addr;
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_RESULT = 3'b100
	} back_state_t;

endpackage

// ===== rtl/core/traffic_class_first_seen_source_unit.sv =====
// Top level of the first-seen source traffic classifier.
// Depends on tcfs_pkg, tcfs_front, tcfs_queue and tcfs_back.
//
//  Channel   Handshake                Data
//  --------  -----------------------  ------------------------------------------
//  input     in_valid / in_stall      ether_type, proto_number, source_address,
//                                     udp_source_port, frame_length
//  output    out_valid / out_stall    category, file_count, game_count,
//                                     voice_count, tcp_count, udp_count, table_fill
//  config    cfg_wen                  cfg_index, cfg_data
//
// An item passes the back end's idle and result states, plus its search state
// when it qualifies for a class and the table is neither empty nor full: the
// search reads one entry per cycle through the single read port and runs up to
// the fill count, ending early on a match. A two-entry queue lets the front take
// items while the back works. Reset clears all control state and counters; the
// table needs no clearing. in_stall rises only when the queue is full; out_stall
// holds the result register and keeps the back end waiting in its result state.

module traffic_class_first_seen_source_unit #(
	parameter int TABLE_DEPTH = tcfs_pkg::TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] ether_type,
	input  logic [7:0]  proto_number,
	input  logic [31:0] source_address,
	input  logic [15:0] udp_source_port,
	input  logic [15:0] frame_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  category,
	output logic [31:0] file_count,
	output logic [31:0] game_count,
	output logic [31:0] voice_count,
	output logic [31:0] tcp_count,
	output logic [31:0] udp_count,
	output logic [7:0]  table_fill
);

	tcfs_pkg::cmd_t front_cmd, head_cmd;
	logic           q_full, q_not_empty, q_pop;

	// Classification
	tcfs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.ether_type     (ether_type),
		.proto_number   (proto_number),
		.source_address (source_address),
		.udp_source_port(udp_source_port),
		.frame_length   (frame_length),
		.cmd            (front_cmd)
	);

	// Decoupling queue; a transfer on the input pushes one command
	assign in_stall = q_full;

	tcfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (head_cmd)
	);

	// Table search, counters and result
	tcfs_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_not_empty),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.category   (category),
		.file_count (file_count),
		.game_count (game_count),
		.voice_count(voice_count),
		.tcp_count  (tcp_count),
		.udp_count  (udp_count),
		.table_fill (table_fill)
	);

endmodule

// ===== rtl/core/tcfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module tcfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/tcfs_front.sv =====
// Front end: configuration registers and header classification.
// Depends on tcfs_pkg.

module tcfs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [15:0]        ether_type,
	input  logic [7:0]         proto_number,
	input  logic [31:0]        source_address,
	input  logic [15:0]        udp_source_port,
	input  logic [15:0]        frame_length,
	output tcfs_pkg::cmd_t     cmd
);

	logic [15:0] bulk_a_q, bulk_b_q, game_a_q, game_b_q;
	logic [15:0] excl_port_q, voice_port_q, voice_lmin_q, voice_lmax_q;
	logic        ipv4, tcp, udp, file_hit, game_hit, voice_hit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bulk_a_q     <= tcfs_pkg::RST_BULK_A;
			bulk_b_q     <= tcfs_pkg::RST_BULK_B;
			game_a_q     <= tcfs_pkg::RST_GAME_A;
			game_b_q     <= tcfs_pkg::RST_GAME_B;
			excl_port_q  <= tcfs_pkg::RST_EXCL_PORT;
			voice_port_q <= tcfs_pkg::RST_VOICE_PORT;
			voice_lmin_q <= tcfs_pkg::RST_VOICE_LMIN;
			voice_lmax_q <= tcfs_pkg::RST_VOICE_LMAX;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tcfs_pkg::REG_BULK_A:     bulk_a_q     <= cfg_data;
				tcfs_pkg::REG_BULK_B:     bulk_b_q     <= cfg_data;
				tcfs_pkg::REG_GAME_A:     game_a_q     <= cfg_data;
				tcfs_pkg::REG_GAME_B:     game_b_q     <= cfg_data;
				tcfs_pkg::REG_EXCL_PORT:  excl_port_q  <= cfg_data;
				tcfs_pkg::REG_VOICE_PORT: voice_port_q <= cfg_data;
				tcfs_pkg::REG_VOICE_LMIN: voice_lmin_q <= cfg_data;
				tcfs_pkg::REG_VOICE_LMAX: voice_lmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Protocol decode
	assign ipv4 = (ether_type == tcfs_pkg::ETHER_IPV4);
	assign tcp  = ipv4 && (proto_number == tcfs_pkg::PROTO_TCP);
	assign udp  = ipv4 && (proto_number == tcfs_pkg::PROTO_UDP);

	// Length and port rules; game takes priority over voice
	assign file_hit  = tcp && ((frame_length == bulk_a_q) || (frame_length == bulk_b_q));
	assign game_hit  = udp && ((frame_length == game_a_q) || (frame_length == game_b_q))
		&& (udp_source_port != excl_port_q);
	assign voice_hit = udp && !game_hit && (udp_source_port > voice_port_q)
		&& (frame_length > voice_lmin_q) && (frame_length < voice_lmax_q);

	// Command for the back end
	always_comb begin
		cmd.is_tcp     = tcp;
		cmd.is_udp     = udp;
		cmd.addr       = source_address;
		cmd.try_insert = file_hit || game_hit || voice_hit;
		if (file_hit) begin
			cmd.cat = tcfs_pkg::CAT_FILE;
		end else if (game_hit) begin
			cmd.cat = tcfs_pkg::CAT_GAME;
		end else if (voice_hit) begin
			cmd.cat = tcfs_pkg::CAT_VOICE;
		end else begin
			cmd.cat = tcfs_pkg::CAT_NONE;
		end
	end

endmodule

// ===== rtl/core/tcfs_queue.sv =====
// Two-entry command queue between front and back ends.
// Depends on tcfs_pkg.

module tcfs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcfs_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output tcfs_pkg::cmd_t head
);

	tcfs_pkg::cmd_t entry_q [2];
	logic           wptr_q, rptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/tcfs_back.sv =====
// Back end: seen-table search, insertion, counters and result register.
// Depends on tcfs_pkg and tcfs_ram.

module tcfs_back #(
	parameter int TABLE_DEPTH = tcfs_pkg::TABLE_DEPTH,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int FW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tcfs_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     category,
	output logic [31:0]    file_count,
	output logic [31:0]    game_count,
	output logic [31:0]    voice_count,
	output logic [31:0]    tcp_count,
	output logic [31:0]    udp_count,
	output logic [7:0]     table_fill
);

	tcfs_pkg::back_state_t state_q;
	tcfs_pkg::cmd_t        cmd_q;
	logic [AW-1:0]         cmp_idx_q, raddr;
	logic [FW-1:0]         fill_q;
	logic                  hit_q, out_valid_q, not_full, last_entry, addr_match;
	logic                  out_free, insert;
	logic [31:0]           rdata;
	logic [31:0]           file_q, game_q, voice_q, tcp_q, udp_q;
	logic [1:0]            category_q;

	assign not_full   = (fill_q < FW'(TABLE_DEPTH));
	assign last_entry = (FW'(cmp_idx_q) == (fill_q - FW'(1)));
	assign addr_match = (rdata == cmd_q.addr);
	assign out_free   = !out_valid_q || !out_stall;
	assign insert     = cmd_q.try_insert && not_full && !hit_q;
	assign cmd_pop    = (state_q == tcfs_pkg::ST_IDLE) && cmd_valid;

	// Read address: the entry after the one in compare while searching, else entry 0
	assign raddr = (state_q == tcfs_pkg::ST_SEARCH) ? (cmp_idx_q + AW'(1)) : '0;

	tcfs_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_seen (
		.clk  (clk),
		.we   ((state_q == tcfs_pkg::ST_RESULT) && out_free && insert),
		.waddr(AW'(fill_q)),
		.wdata(cmd_q.addr),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Sequencer, table fill and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcfs_pkg::ST_IDLE;
			cmp_idx_q   <= '0;
			hit_q       <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			category_q  <= tcfs_pkg::CAT_NONE;
			file_q      <= '0;
			game_q      <= '0;
			voice_q     <= '0;
			tcp_q       <= '0;
			udp_q       <= '0;
		end else begin
			// result valid: set on a load, cleared once taken
			if ((state_q == tcfs_pkg::ST_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tcfs_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						hit_q     <= 1'b0;
						cmp_idx_q <= '0;
						if (cmd.try_insert && not_full && (fill_q != '0)) begin
							state_q <= tcfs_pkg::ST_SEARCH;
						end else begin
							state_q <= tcfs_pkg::ST_RESULT;
						end
					end
				end
				tcfs_pkg::ST_SEARCH: begin
					if (addr_match) begin
						hit_q   <= 1'b1;
						state_q <= tcfs_pkg::ST_RESULT;
					end else if (last_entry) begin
						state_q <= tcfs_pkg::ST_RESULT;
					end else begin
						cmp_idx_q <= cmp_idx_q + AW'(1);
					end
				end
				tcfs_pkg::ST_RESULT: begin
					if (out_free) begin
						category_q  <= insert ? cmd_q.cat : tcfs_pkg::CAT_NONE;
						tcp_q       <= tcp_q + 32'(cmd_q.is_tcp);
						udp_q       <= udp_q + 32'(cmd_q.is_udp);
						if (insert) begin
							fill_q <= fill_q + FW'(1);
						end
						if (insert && (cmd_q.cat == tcfs_pkg::CAT_FILE)) begin
							file_q <= file_q + 32'd1;
						end
						if (insert && (cmd_q.cat == tcfs_pkg::CAT_GAME)) begin
							game_q <= game_q + 32'd1;
						end
						if (insert && (cmd_q.cat == tcfs_pkg::CAT_VOICE)) begin
							voice_q <= voice_q + 32'd1;
						end
						state_q <= tcfs_pkg::ST_IDLE;
					end
				end
				default: state_q <= tcfs_pkg::ST_IDLE;
			endcase
		end
	end

	// Command being worked on
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	// Totals only move when a result is loaded, so they double as the output register
	assign out_valid   = out_valid_q;
	assign category    = category_q;
	assign file_count  = file_q;
	assign game_count  = game_q;
	assign voice_count = voice_q;
	assign tcp_count   = tcp_q;
	assign udp_count   = udp_q;
	assign table_fill  = 8'(fill_q);

endmodule
